>>> rtl/cfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfpa_pkg: shared types, constants and helpers
// Opcodes, controller commands, status codes and the saturation helpers that
// the complex fixed-point unit uses.
// ----------------------------------------------------------------------------
package cfpa_pkg;

    localparam int MAX_EXP_DEFAULT = 255;

    // Opcodes.
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_CONJ  = 4'd4;
    localparam logic [3:0] OP_NEG   = 4'd5;
    localparam logic [3:0] OP_MAGSQ = 4'd6;
    localparam logic [3:0] OP_ABS   = 4'd7;
    localparam logic [3:0] OP_INV   = 4'd8;
    localparam logic [3:0] OP_POW   = 4'd9;
    localparam logic [3:0] OP_EQUAL = 4'd10;

    // Status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // Quotient bits of the divider (n * 2^17 / d) and steps of the root.
    localparam int DIV_STEPS = 81;
    localparam int SQ_STEPS  = 32;

    typedef enum logic [3:0] {
        C_IDLE,
        C_LOAD,
        C_MUL,
        C_SUM_MUL,
        C_SUM_DIV,
        C_CMUL_FIN,
        C_MAGSQ_FIN,
        C_DEN,
        C_DIV_INIT,
        C_DIV_STEP,
        C_DIV_FIN,
        C_SQ_INIT,
        C_SQ_STEP,
        C_SQ_FIN,
        C_SET_ONE,
        C_DZ
    } t_cmd;

    // Multiplier operand pairs (x, y).
    typedef enum logic [2:0] {
        MS_AB,
        MS_AA,
        MS_BB,
        MS_1A,
        MS_RC
    } t_msel;

    typedef struct packed {
        t_cmd  op;
        t_msel msel;
        logic  to_base;
        logic  push;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] opcode;
        logic       exp_neg;
        logic [8:0] exp_mag;
        logic       s0_zero;
        logic       out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_word_sat;

    // Saturate a sign-magnitude value to a signed 32-bit word.
    function automatic t_word_sat to_word(input logic [63:0] mag, input logic neg);
        t_word_sat w;
        w.ovf = 1'b0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                w.val = 32'h8000_0000;
                w.ovf = 1'b1;
            end else begin
                w.val = 32'(-mag);
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                w.val = 32'h7FFF_FFFF;
                w.ovf = 1'b1;
            end else begin
                w.val = mag[31:0];
            end
        end
        return w;
    endfunction

    function automatic t_word_sat sat33(input logic signed [32:0] v);
        logic [32:0] mag;
        mag = v[32] ? 33'(-v) : 33'(v);
        return to_word({31'b0, mag}, v[32]);
    endfunction

    // Round a Q32.32 sum to Q16.16, ties away from zero, then saturate.
    function automatic t_word_sat round_word(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [64:0] m;
        mag = v[65] ? 66'(-v) : 66'(v);
        m   = {1'b0, mag[63:0]} + 65'd32768;
        return to_word({15'b0, m[64:16]}, v[65]);
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [63:0] p);
        return {{2{p[63]}}, p};
    endfunction

endpackage
`default_nettype wire

>>> rtl/cfpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfpa_dp: datapath of the complex unit
// Operand and result registers, four parallel multipliers, the sum stage, a
// two-lane restoring divider, a bit-pair square root and the output register.
// ----------------------------------------------------------------------------
module cfpa_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  cfpa_pkg::t_dp_cmd     i_cmd,
    output cfpa_pkg::t_dp_sts     o_sts,
    input  wire [3:0]             i_opcode,
    input  wire signed [31:0]     i_a_re,
    input  wire signed [31:0]     i_a_im,
    input  wire signed [31:0]     i_b_re,
    input  wire signed [31:0]     i_b_im,
    input  wire signed [8:0]      i_exponent,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic signed [31:0]    o_res_re,
    output logic signed [31:0]    o_res_im,
    output logic [1:0]            o_status,
    output logic                  o_equal
);
    import cfpa_pkg::*;

    logic [3:0]          r_op;
    logic signed [8:0]   r_exp;
    logic signed [31:0]  r_ar, r_ai, r_br, r_bi;
    logic signed [31:0]  r_cr, r_ci;           // power base
    logic signed [31:0]  r_rr, r_ri;           // working result
    logic                r_ovf, r_dz, r_eq;
    logic signed [63:0]  r_p0, r_p1, r_p2, r_p3;
    logic signed [65:0]  r_s0, r_s1;
    logic [63:0]         r_den;
    logic [80:0]         r_dvd [2];
    logic [63:0]         r_rem [2];
    logic [35:0]         r_q   [2];
    logic                r_big [2];
    logic                r_qneg [2];
    logic [63:0]         r_sqn, r_sqr, r_bit;
    logic                r_ovalid;
    logic signed [31:0]  r_ore, r_oim;
    logic [1:0]          r_ost;
    logic                r_oeq;

    logic signed [31:0]  mx_re, mx_im, my_re, my_im;
    t_word_sat           s_re, s_im, cm_re, cm_im, mq, dv0, dv1, sq;
    logic signed [31:0]  s_rr, s_ri;
    logic                s_ovf, s_eq;
    logic [64:0]         trial [2];
    logic                ge [2];
    logic [36:0]         qr [2];
    logic [65:0]         nmag [2];
    logic [63:0]         sq_t;

    // Operand selection for the multipliers.
    always_comb begin
        unique case (i_cmd.msel)
            MS_AB: begin
                mx_re = r_ar; mx_im = r_ai; my_re = r_br; my_im = r_bi;
            end
            MS_AA: begin
                mx_re = r_ar; mx_im = r_ai; my_re = r_ar; my_im = r_ai;
            end
            MS_BB: begin
                mx_re = r_br; mx_im = r_bi; my_re = r_br; my_im = r_bi;
            end
            MS_1A: begin
                mx_re = ONE_Q16; mx_im = '0; my_re = r_ar; my_im = r_ai;
            end
            MS_RC: begin
                mx_re = r_rr; mx_im = r_ri; my_re = r_cr; my_im = r_ci;
            end
            default: begin
                mx_re = r_ar; mx_im = r_ai; my_re = r_br; my_im = r_bi;
            end
        endcase
    end

    // Operations computed straight from the input word and captured at load.
    always_comb begin
        s_re  = sat33(33'sd0);
        s_im  = sat33(33'sd0);
        s_eq  = 1'b0;
        unique case (i_opcode)
            OP_ADD: begin
                s_re = sat33(33'(i_a_re) + 33'(i_b_re));
                s_im = sat33(33'(i_a_im) + 33'(i_b_im));
            end
            OP_SUB: begin
                s_re = sat33(33'(i_a_re) - 33'(i_b_re));
                s_im = sat33(33'(i_a_im) - 33'(i_b_im));
            end
            OP_CONJ: begin
                s_re = sat33(33'(i_a_re));
                s_im = sat33(-33'(i_a_im));
            end
            OP_NEG: begin
                s_re = sat33(-33'(i_a_re));
                s_im = sat33(-33'(i_a_im));
            end
            OP_EQUAL: begin
                s_eq = (i_a_re == i_b_re) && (i_a_im == i_b_im);
            end
            default: begin
                s_eq = 1'b0;
            end
        endcase
        s_rr  = s_re.val;
        s_ri  = s_im.val;
        s_ovf = s_re.ovf | s_im.ovf;
    end

    always_comb begin
        cm_re = round_word(r_s0);
        cm_im = round_word(r_s1);
        mq    = round_word(r_s0);
        sq    = to_word(r_sqr, 1'b0);
        sq_t  = r_sqr + r_bit;
        for (int k = 0; k < 2; k++) begin
            trial[k] = {r_rem[k], r_dvd[k][80]};
            ge[k]    = trial[k] >= {1'b0, r_den};
            qr[k]    = {1'b0, r_q[k]} + 37'd1;
        end
        nmag[0] = r_s0[65] ? 66'(-r_s0) : 66'(r_s0);
        nmag[1] = r_s1[65] ? 66'(-r_s1) : 66'(r_s1);
        dv0 = r_big[0] ? to_word('1, r_qneg[0]) : to_word({28'b0, qr[0][36:1]}, r_qneg[0]);
        dv1 = r_big[1] ? to_word('1, r_qneg[1]) : to_word({28'b0, qr[1][36:1]}, r_qneg[1]);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            C_LOAD: begin
                r_op  <= i_opcode;
                r_exp <= i_exponent;
                r_ar  <= i_a_re;
                r_ai  <= i_a_im;
                r_br  <= i_b_re;
                r_bi  <= i_b_im;
                r_cr  <= i_a_re;
                r_ci  <= i_a_im;
                r_rr  <= s_rr;
                r_ri  <= s_ri;
                r_ovf <= s_ovf;
                r_eq  <= s_eq;
                r_dz  <= 1'b0;
            end
            C_MUL: begin
                r_p0 <= mx_re * my_re;
                r_p1 <= mx_im * my_im;
                r_p2 <= mx_re * my_im;
                r_p3 <= mx_im * my_re;
            end
            C_SUM_MUL: begin
                r_s0 <= sx66(r_p0) - sx66(r_p1);
                r_s1 <= sx66(r_p2) + sx66(r_p3);
            end
            C_SUM_DIV: begin
                r_s0 <= sx66(r_p0) + sx66(r_p1);
                r_s1 <= sx66(r_p3) - sx66(r_p2);
            end
            C_CMUL_FIN: begin
                r_rr  <= cm_re.val;
                r_ri  <= cm_im.val;
                r_ovf <= r_ovf | cm_re.ovf | cm_im.ovf;
            end
            C_MAGSQ_FIN: begin
                r_rr  <= mq.val;
                r_ri  <= '0;
                r_ovf <= r_ovf | mq.ovf;
            end
            C_DEN: begin
                r_den <= r_s0[63:0];
            end
            C_DIV_INIT: begin
                for (int k = 0; k < 2; k++) begin
                    r_dvd[k]  <= {nmag[k][63:0], 17'b0};
                    r_rem[k]  <= '0;
                    r_q[k]    <= '0;
                    r_big[k]  <= 1'b0;
                end
                r_qneg[0] <= r_s0[65];
                r_qneg[1] <= r_s1[65];
            end
            C_DIV_STEP: begin
                for (int k = 0; k < 2; k++) begin
                    r_rem[k] <= ge[k] ? 64'(trial[k] - {1'b0, r_den}) : trial[k][63:0];
                    r_dvd[k] <= {r_dvd[k][79:0], 1'b0};
                    r_q[k]   <= {r_q[k][34:0], ge[k]};
                    r_big[k] <= r_big[k] | r_q[k][35];
                end
            end
            C_DIV_FIN: begin
                if (i_cmd.to_base) begin
                    r_cr <= dv0.val;
                    r_ci <= dv1.val;
                end else begin
                    r_rr <= dv0.val;
                    r_ri <= dv1.val;
                end
                r_ovf <= r_ovf | dv0.ovf | dv1.ovf;
            end
            C_SQ_INIT: begin
                r_sqn <= r_s0[63:0];
                r_sqr <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            C_SQ_STEP: begin
                if (r_sqn >= sq_t) begin
                    r_sqn <= r_sqn - sq_t;
                    r_sqr <= (r_sqr >> 1) + r_bit;
                end else begin
                    r_sqr <= r_sqr >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            C_SQ_FIN: begin
                r_rr  <= sq.val;
                r_ri  <= '0;
                r_ovf <= r_ovf | sq.ovf;
            end
            C_SET_ONE: begin
                r_rr <= ONE_Q16;
                r_ri <= '0;
            end
            C_DZ: begin
                r_rr <= '0;
                r_ri <= '0;
                r_dz <= 1'b1;
            end
            default: begin
                r_rr <= r_rr;
            end
        endcase

        if (i_cmd.push) begin
            r_ore <= r_rr;
            r_oim <= r_ri;
            r_ost <= r_dz ? ST_DZ : (r_ovf ? ST_OVF : ST_OK);
            r_oeq <= r_eq;
        end
    end

    // Output register: valid holds until the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.opcode   = r_op;
        o_sts.exp_neg  = r_exp[8];
        o_sts.exp_mag  = r_exp[8] ? 9'(-r_exp) : 9'(r_exp);
        o_sts.s0_zero  = (r_s0 == '0);
        o_sts.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_res_re    = r_ore;
    assign o_res_im    = r_oim;
    assign o_status    = r_ost;
    assign o_equal     = r_oeq;

endmodule
`default_nettype wire

>>> rtl/cfpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfpa_ctrl: sequencer of the complex unit
// Walks each opcode through multiply, sum, divide, root and power steps and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module cfpa_ctrl #(
    parameter int MAX_EXPONENT = cfpa_pkg::MAX_EXP_DEFAULT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  cfpa_pkg::t_dp_sts  i_sts,
    output cfpa_pkg::t_dp_cmd  o_cmd
);
    import cfpa_pkg::*;

    localparam int          KW   = $clog2(MAX_EXPONENT + 1);
    localparam logic [16:0] MAXV = 17'(MAX_EXPONENT);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_SQ_MUL, S_SQ_SUM, S_MAGSQ_FIN, S_SQ_INIT, S_SQ_STEP, S_SQ_FIN,
        S_DEN_MUL, S_DEN_SUM, S_DEN, S_NUM_MUL, S_NUM_SUM,
        S_DIV_INIT, S_DIV_STEP, S_DIV_FIN, S_DZ,
        S_ONE, S_CM_MUL, S_CM_SUM, S_CM_FIN, S_OUT
    } t_state;

    t_state          r_state;
    logic [6:0]      r_cnt;
    logic [KW-1:0]   r_pow;
    logic [KW-1:0]   k_pow;
    logic            is_pow;

    assign is_pow = (i_sts.opcode == OP_POW);

    // Clamp the exponent magnitude.
    always_comb begin
        if ({8'b0, i_sts.exp_mag} > MAXV) begin
            k_pow = KW'(MAXV);
        end else begin
            k_pow = KW'(i_sts.exp_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pow   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    unique case (i_sts.opcode)
                        OP_MUL:            r_state <= S_CM_MUL;
                        OP_MAGSQ, OP_ABS:  r_state <= S_SQ_MUL;
                        OP_DIV, OP_INV:    r_state <= S_DEN_MUL;
                        OP_POW:            r_state <= i_sts.exp_neg ? S_DEN_MUL : S_ONE;
                        default:           r_state <= S_OUT;
                    endcase
                end
                S_SQ_MUL: r_state <= S_SQ_SUM;
                S_SQ_SUM: r_state <= (i_sts.opcode == OP_ABS) ? S_SQ_INIT : S_MAGSQ_FIN;
                S_MAGSQ_FIN: r_state <= S_OUT;
                S_SQ_INIT: begin
                    r_cnt   <= 7'(SQ_STEPS - 1);
                    r_state <= S_SQ_STEP;
                end
                S_SQ_STEP: begin
                    if (r_cnt == '0) r_state <= S_SQ_FIN;
                    r_cnt <= r_cnt - 7'd1;
                end
                S_SQ_FIN:  r_state <= S_OUT;
                S_DEN_MUL: r_state <= S_DEN_SUM;
                S_DEN_SUM: r_state <= S_DEN;
                S_DEN:     r_state <= i_sts.s0_zero ? S_DZ : S_NUM_MUL;
                S_NUM_MUL: r_state <= S_NUM_SUM;
                S_NUM_SUM: r_state <= S_DIV_INIT;
                S_DIV_INIT: begin
                    r_cnt   <= 7'(DIV_STEPS - 1);
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    if (r_cnt == '0) r_state <= S_DIV_FIN;
                    r_cnt <= r_cnt - 7'd1;
                end
                S_DIV_FIN: r_state <= is_pow ? S_ONE : S_OUT;
                S_DZ:      r_state <= S_OUT;
                S_ONE: begin
                    r_pow   <= k_pow;
                    r_state <= (k_pow == '0) ? S_OUT : S_CM_MUL;
                end
                S_CM_MUL: r_state <= S_CM_SUM;
                S_CM_SUM: r_state <= S_CM_FIN;
                S_CM_FIN: begin
                    if (is_pow && (r_pow > KW'(1))) begin
                        r_pow   <= r_pow - KW'(1);
                        r_state <= S_CM_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.op      = C_IDLE;
        o_cmd.msel    = MS_AB;
        o_cmd.to_base = is_pow;
        o_cmd.push    = 1'b0;
        unique case (r_state)
            S_IDLE:      o_cmd.op = i_in_valid ? C_LOAD : C_IDLE;
            S_SQ_MUL: begin
                o_cmd.op   = C_MUL;
                o_cmd.msel = MS_AA;
            end
            S_SQ_SUM:    o_cmd.op = C_SUM_DIV;
            S_MAGSQ_FIN: o_cmd.op = C_MAGSQ_FIN;
            S_SQ_INIT:   o_cmd.op = C_SQ_INIT;
            S_SQ_STEP:   o_cmd.op = C_SQ_STEP;
            S_SQ_FIN:    o_cmd.op = C_SQ_FIN;
            S_DEN_MUL: begin
                o_cmd.op   = C_MUL;
                o_cmd.msel = (i_sts.opcode == OP_DIV) ? MS_BB : MS_AA;
            end
            S_DEN_SUM:   o_cmd.op = C_SUM_DIV;
            S_DEN:       o_cmd.op = C_DEN;
            S_NUM_MUL: begin
                o_cmd.op   = C_MUL;
                o_cmd.msel = (i_sts.opcode == OP_DIV) ? MS_AB : MS_1A;
            end
            S_NUM_SUM:   o_cmd.op = C_SUM_DIV;
            S_DIV_INIT:  o_cmd.op = C_DIV_INIT;
            S_DIV_STEP:  o_cmd.op = C_DIV_STEP;
            S_DIV_FIN:   o_cmd.op = C_DIV_FIN;
            S_DZ:        o_cmd.op = C_DZ;
            S_ONE:       o_cmd.op = C_SET_ONE;
            S_CM_MUL: begin
                o_cmd.op   = C_MUL;
                o_cmd.msel = is_pow ? MS_RC : MS_AB;
            end
            S_CM_SUM:    o_cmd.op = C_SUM_MUL;
            S_CM_FIN:    o_cmd.op = C_CMUL_FIN;
            S_OUT:       o_cmd.push = i_sts.out_free;
            default:     o_cmd.op = C_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

>>> rtl/complex_fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fixed_point_alu: complex Q16.16 arithmetic unit
// Add, subtract, multiply, divide, conjugate, negate, magnitude squared,
// magnitude, inverse, integer power and equality test on complex operands.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Word contents
// s_axis    in   tdata: a_re, a_im, b_re, b_im, exponent; tuser: opcode
// m_axis    out  tdata: res_re, res_im; tuser: status, equal
//
// One word is processed at a time. Add, subtract, conjugate, negate and equal
// are computed from the input word as it is accepted; multiply and magnitude
// squared take one complex product, magnitude then 32 root steps; divide and
// inverse take 81 quotient steps in two parallel lanes. Power repeats the
// complex product up to MAX_EXPONENT times on the shared four-multiplier
// product stage, after an inversion when the exponent is negative.
// Reset is synchronous and active low and clears the sequencer and the output
// valid. The next input word is taken while a finished word waits on m_axis.
//
module complex_fixed_point_alu #(
    parameter int MAX_EXPONENT = cfpa_pkg::MAX_EXP_DEFAULT  // 1 to 65535
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] a_re, [63:32] a_im, [95:64] b_re, [127:96] b_im,
    // [136:128] exponent, [143:137] zero
    input  wire [143:0]  s_axis_tdata,
    // [3:0] opcode
    input  wire [3:0]    s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [31:0] res_re, [63:32] res_im
    output logic [63:0]  m_axis_tdata,
    // [1:0] status, [2] equal
    output logic [2:0]   m_axis_tuser
);
    import cfpa_pkg::*;

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic signed [31:0]  res_re, res_im;
    logic [1:0]          status;
    logic                equal;

    // The sequencer owns the input handshake and steps the datapath.
    cfpa_ctrl #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the operands, arithmetic units and output register.
    cfpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (s_axis_tuser),
        .i_a_re      (s_axis_tdata[31:0]),
        .i_a_im      (s_axis_tdata[63:32]),
        .i_b_re      (s_axis_tdata[95:64]),
        .i_b_im      (s_axis_tdata[127:96]),
        .i_exponent  (s_axis_tdata[136:128]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_res_re    (res_re),
        .o_res_im    (res_im),
        .o_status    (status),
        .o_equal     (equal)
    );

    assign m_axis_tdata = {res_im, res_re};
    assign m_axis_tuser = {equal, status};

endmodule
`default_nettype wire
